// ===== hw/rtl/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants for the text integer scanner.
// ----------------------------------------------------------------------------
package tis_pkg;

    // Scan phases.
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_DEC    = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;

    localparam logic [15:0] LEN_MAX  = 16'hFFFF;

    // One finished scan.
    typedef struct packed {
        logic               ok;
        logic signed [31:0] value;
        logic [15:0]        length;
    } tis_result_t;

endpackage

// ===== hw/rtl/text_integer_scanner.sv =====
// ----------------------------------------------------------------------------
// text_integer_scanner
// Parses a signed decimal or hex integer from a stream of ASCII characters.
// ----------------------------------------------------------------------------
// One character word is taken per clock, back to back, and a result word is
// produced for the character that ends a number (that character is not
// counted). Leading space, CR, LF and tab are skipped, then an optional sign,
// then either "$" or "0x" for hex digits (either case) or plain decimal digits.
// Each character is held in the input register, where the whole parse step is
// done, and the result of a terminating character is then registered in a
// two-entry output buffer, whose main entry drives out_valid until the word is
// taken with out_stall low. The input stalls
// only when a terminating character meets a full output buffer.
// ok is 0 when no digit was seen, and value and length are then 0; value wraps
// modulo 2^32 and length saturates at 65535.
module text_integer_scanner
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [31:0] value,
    output logic [15:0]        length
);
    import tis_pkg::*;

    logic        res_ready;
    logic        res_push;
    tis_result_t res;
    tis_result_t out_data;

    tis_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res       (res)
    );

    tis_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .ready     (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign ok     = out_data.ok;
    assign value  = out_data.value;
    assign length = out_data.length;

endmodule

// ===== hw/rtl/tis_scan.sv =====
// ----------------------------------------------------------------------------
// tis_scan
// Input register, scan state and the per-character parse step.
// ----------------------------------------------------------------------------
module tis_scan
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           char_code,
    input  logic                 res_ready,
    output logic                 res_push,
    output tis_pkg::tis_result_t res
);
    import tis_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;

    logic [2:0]  phase_reg,  phase_next;
    logic [31:0] acc_reg,    acc_next;
    logic        neg_reg,    neg_next;
    logic        seen_reg,   seen_next;
    logic [15:0] cnt_reg,    cnt_next;

    logic        emit;
    logic        fire;
    logic        accept;

    logic [2:0]  ph;
    logic [31:0] acc_eff;
    logic        seen_eff;
    logic        finish;
    logic        count;
    logic        is_dec;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [15:0] cnt_inc;

    assign is_dec = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (is_dec)
        begin
            hex_val = 4'(char_reg - CH_ZERO);
        end
        else if ((char_reg >= CH_LC_A) && (char_reg <= CH_LC_F))
        begin
            hex_val = 4'(char_reg - CH_LC_A + 8'd10);
        end
        else if ((char_reg >= CH_UC_A) && (char_reg <= CH_UC_F))
        begin
            hex_val = 4'(char_reg - CH_UC_A + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign cnt_inc = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + 16'd1;

    // Follows the phases in order; a character can fall through from
    // whitespace to the post-sign phase and from a held zero to decimal digits.
    always_comb
    begin
        ph         = phase_reg;
        acc_eff    = acc_reg;
        seen_eff   = seen_reg;
        finish     = 1'b0;
        count      = 1'b0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;

        if (ph == PH_SPACE)
        begin
            if ((char_reg == CH_SPACE) || (char_reg == CH_CR) ||
                (char_reg == CH_LF) || (char_reg == CH_TAB))
            begin
                count = 1'b1;
            end
            else if (char_reg == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_SIGNED;
                count      = 1'b1;
            end
            else if (char_reg == CH_PLUS)
            begin
                phase_next = PH_SIGNED;
                count      = 1'b1;
            end
            else
            begin
                ph = PH_SIGNED;
            end
        end

        if (!count)
        begin
            unique case (ph)
                PH_SPACE:
                begin
                    finish = 1'b0;
                end
                PH_SIGNED:
                begin
                    if (char_reg == CH_DOLLAR)
                    begin
                        phase_next = PH_HEX;
                        count      = 1'b1;
                    end
                    else if (char_reg == CH_ZERO)
                    begin
                        phase_next = PH_ZERO;
                        count      = 1'b1;
                    end
                    else if ((char_reg >= CH_ONE) && (char_reg <= CH_NINE))
                    begin
                        acc_next   = {28'd0, hex_val};
                        seen_next  = 1'b1;
                        phase_next = PH_DEC;
                        count      = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (char_reg == CH_X)
                    begin
                        phase_next = PH_HEX;
                        count      = 1'b1;
                    end
                    else
                    begin
                        // The held zero becomes a decimal digit.
                        acc_eff    = 32'd0;
                        seen_eff   = 1'b1;
                        seen_next  = 1'b1;
                        phase_next = PH_DEC;
                        if (is_dec)
                        begin
                            acc_next = {28'd0, hex_val};
                            count    = 1'b1;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                PH_HEX:
                begin
                    if (is_hex)
                    begin
                        acc_next  = {acc_reg[27:0], hex_val};
                        seen_next = 1'b1;
                        count     = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_DEC:
                begin
                    if (is_dec)
                    begin
                        acc_next  = (acc_reg << 3) + (acc_reg << 1) + {28'd0, hex_val};
                        seen_next = 1'b1;
                        count     = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase
        end

        cnt_next = count ? cnt_inc : cnt_reg;

        if (finish)
        begin
            phase_next = PH_SPACE;
            acc_next   = 32'd0;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            cnt_next   = 16'd0;
        end
    end

    always_comb
    begin
        res.ok     = seen_eff;
        res.value  = 32'sd0;
        res.length = 16'd0;
        if (seen_eff)
        begin
            res.value  = neg_reg ? -$signed(acc_eff) : $signed(acc_eff);
            res.length = cnt_reg;
        end
    end

    assign emit     = finish;
    assign fire     = in_valid_reg && (!emit || res_ready);
    assign res_push = in_valid_reg && emit && res_ready;
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_SPACE;
            acc_reg      <= 32'd0;
            neg_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            cnt_reg      <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
        end
    end

endmodule

// ===== hw/rtl/tis_out_buf.sv =====
// ----------------------------------------------------------------------------
// tis_out_buf
// Result register with a skid entry so the scanner keeps running while a
// result waits on the output.
// ----------------------------------------------------------------------------
module tis_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tis_pkg::tis_result_t push_data,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tis_pkg::tis_result_t out_data
);
    import tis_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    tis_result_t main_reg,       main_next;
    tis_result_t skid_reg,       skid_next;
    logic        pop;

    assign pop       = main_valid_reg && !out_stall;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // A push only arrives while the skid entry is empty.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
